>>> sv/fssa_pkg.sv
// Package for the format-sized slot allocator: sizes, status codes, commands
// and the command/status structs that join controller and datapath.
// No dependencies.
package fssa_pkg;

  localparam int SLOTS        = 4096;
  localparam int BUFFERS      = 32;
  localparam int SIZE_CLASSES = 64;
  localparam int FORMATS      = 18;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int BUF_W  = $clog2(BUFFERS);
  localparam int CLS_W  = $clog2(SIZE_CLASSES);
  localparam int FMT_W  = 5;
  localparam int FI_W   = $clog2(FORMATS * SIZE_CLASSES);
  localparam int ELEM_W = 16;
  localparam int LEN_W  = 12;
  localparam int ST_W   = 3;

  localparam logic [ST_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [ST_W-1:0] ST_CARVED   = 3'd1;
  localparam logic [ST_W-1:0] ST_NEWBUF   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOSTORE  = 3'd3;
  localparam logic [ST_W-1:0] ST_BADSIZE  = 3'd4;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd5;

  localparam logic CMD_GET     = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [ELEM_W-1:0] MIN_BUF_RESET = 16'd8192;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LATCH    = 4'd1;  // capture the input beat
  localparam logic [3:0] OP_RD_HEAD  = 4'd2;  // read slot record of released slot
  localparam logic [3:0] OP_RD_SLOT  = 4'd3;  // read slot record at head; release: set class
  localparam logic [3:0] OP_POP      = 4'd4;  // pop free list, emit reused
  localparam logic [3:0] OP_WALK     = 4'd5;  // load chain head into walker
  localparam logic [3:0] OP_STEP     = 4'd6;  // follow buffer link
  localparam logic [3:0] OP_CARVE    = 4'd7;  // carve from walked buffer
  localparam logic [3:0] OP_NEWBUF   = 4'd8;  // open new buffer
  localparam logic [3:0] OP_PUSH     = 4'd9;  // push released slot
  localparam logic [3:0] OP_EMIT_BAD = 4'd10;
  localparam logic [3:0] OP_EMIT_NOS = 4'd11;
  localparam logic [3:0] OP_EMIT_IGN = 4'd12;

  typedef struct packed {
    logic [3:0] op;
  } fssa_cmd_t;

  typedef struct packed {
    logic is_release;
    logic bad_req;
    logic rel_ignored;
    logic free_hit;
    logic slots_full;
    logic buffers_full;
    logic walk_end;
    logic walk_fits;
    logic init_done;
  } fssa_stat_t;

endpackage

>>> sv/fssa_datapath.sv
// Datapath of the slot allocator: slot and free-head memories, buffer
// tables, chain walker and the result register. Depends on fssa_pkg.
module fssa_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fssa_pkg::fssa_cmd_t     cmd,
  output fssa_pkg::fssa_stat_t    stat,
  input  logic [15:0]             min_buf,
  input  logic                    in_cmd,
  input  logic [4:0]              in_fmt,
  input  logic [15:0]             in_size,
  input  logic [11:0]             in_rel,
  output logic [2:0]              res_status,
  output logic [11:0]             res_slot,
  output logic [4:0]              res_buf,
  output logic [15:0]             res_off,
  output logic [11:0]             res_len
);
  import fssa_pkg::*;

  // Slot record memory: length, offset, owner, free link (SLOTS = empty).
  logic [LEN_W-1:0]  slot_len_mem  [SLOTS];
  logic [ELEM_W-1:0] slot_off_mem  [SLOTS];
  logic [BUF_W-1:0]  slot_own_mem  [SLOTS];
  logic [SLOT_W:0]   slot_link_mem [SLOTS];
  // Free-list heads, cleared by a sweep after reset.
  logic [SLOT_W:0]   free_mem [FORMATS*SIZE_CLASSES];

  // Buffer tables (32 entries, read at the walker index; formats also at an owner).
  logic [FMT_W-1:0]  buf_fmt_r  [BUFFERS];
  logic [ELEM_W-1:0] buf_fill_r [BUFFERS];
  logic [ELEM_W-1:0] buf_cap_r  [BUFFERS];
  logic [BUF_W:0]    buf_link_r [BUFFERS];
  logic [BUF_W:0]    chain_r    [FORMATS];
  logic [FORMATS-1:0] chain_vld_r;

  logic [SLOT_W:0]   slots_used_r;
  logic [BUF_W:0]    bufs_used_r;
  logic [FI_W:0]     init_cnt_r;

  logic              cmd_r;
  logic [FMT_W-1:0]  fmt_r;
  logic [LEN_W-1:0]  size_r;
  logic [SLOT_W-1:0] rel_r;
  logic              bad_r;
  logic [FI_W-1:0]   fi_r;
  logic [SLOT_W:0]   head_r;
  logic [BUF_W:0]    walk_r;

  // Registered memory read data.
  logic [LEN_W-1:0]  rd_len_r;
  logic [ELEM_W-1:0] rd_off_r;
  logic [BUF_W-1:0]  rd_own_r;
  logic [SLOT_W:0]   rd_link_r;
  logic [SLOT_W:0]   rd_head_r;

  logic [16:0]       size_sum;
  logic [LEN_W-1:0]  size_rnd;
  logic              bad_now;
  logic [CLS_W-1:0]  cls_get;
  logic [CLS_W-1:0]  cls_rel;
  logic [FI_W-1:0]   fi_get;
  logic [BUF_W-1:0]  walk_idx;
  logic [ELEM_W-1:0] room;
  logic [BUF_W-1:0]  rel_fmt_buf;
  logic [FMT_W-1:0]  rel_fmt;
  logic [BUF_W:0]    chain_head_now;
  logic [ELEM_W-1:0] new_cap;
  logic [SLOT_W-1:0] s_idx;
  logic [SLOT_W-1:0] rd_addr;
  logic [FI_W-1:0]   fi_rel;

  // Size rounding and classification of the incoming beat.
  always_comb begin
    size_sum = {1'b0, in_size} + 17'd31;
    bad_now  = (in_size == '0) || (size_sum[16:5] > 12'(SIZE_CLASSES))
               || (in_fmt >= 5'(FORMATS));
    size_rnd = {size_sum[11:5], 5'd0};
    cls_get  = CLS_W'(size_sum[16:5] - 12'd1);
    fi_get   = FI_W'(in_fmt) * FI_W'(SIZE_CLASSES) + FI_W'(cls_get);
  end

  assign walk_idx       = walk_r[BUF_W-1:0];
  assign room           = buf_cap_r[walk_idx] - buf_fill_r[walk_idx];
  assign chain_head_now = chain_vld_r[fmt_r] ? chain_r[fmt_r] : (BUF_W+1)'(BUFFERS);
  assign new_cap        = (min_buf > ELEM_W'(size_r)) ? min_buf : ELEM_W'(size_r);
  assign s_idx          = slots_used_r[SLOT_W-1:0];
  assign rel_fmt_buf    = rd_own_r;
  assign rel_fmt        = buf_fmt_r[rel_fmt_buf];
  assign cls_rel        = CLS_W'((rd_len_r >> 5) - 12'd1);
  assign fi_rel         = FI_W'(rel_fmt) * FI_W'(SIZE_CLASSES) + FI_W'(cls_rel);
  // A release reads the record of the slot it frees; a get reads the record at the free head.
  assign rd_addr        = (cmd_r == CMD_RELEASE) ? rel_r : rd_head_r[SLOT_W-1:0];

  always_comb begin
    stat.is_release   = cmd_r;
    stat.bad_req      = bad_r;
    stat.rel_ignored  = {1'b0, rel_r} >= slots_used_r;
    stat.free_hit     = rd_head_r < (SLOT_W+1)'(SLOTS);
    stat.slots_full   = slots_used_r >= (SLOT_W+1)'(SLOTS);
    stat.buffers_full = bufs_used_r >= (BUF_W+1)'(BUFFERS);
    stat.walk_end     = walk_r >= (BUF_W+1)'(BUFFERS);
    stat.walk_fits    = room >= ELEM_W'(size_r);
    stat.init_done    = init_cnt_r == (FI_W+1)'(FORMATS*SIZE_CLASSES);
  end

  // Control counters and the chain-valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
      bufs_used_r  <= '0;
      init_cnt_r   <= '0;
      chain_vld_r  <= '0;
    end else begin
      if (!stat.init_done) init_cnt_r <= init_cnt_r + 1'b1;
      if (cmd.op == OP_CARVE) slots_used_r <= slots_used_r + 1'b1;
      if (cmd.op == OP_NEWBUF) begin
        slots_used_r <= slots_used_r + 1'b1;
        bufs_used_r  <= bufs_used_r + 1'b1;
        chain_vld_r[fmt_r] <= 1'b1;
      end
    end
  end

  // Free-head memory: clearing sweep, pop and push writes, registered read.
  always_ff @(posedge clk) begin
    if (!stat.init_done)
      free_mem[init_cnt_r[FI_W-1:0]] <= (SLOT_W+1)'(SLOTS);
    else if (cmd.op == OP_POP)
      free_mem[fi_r] <= rd_link_r;
    else if (cmd.op == OP_PUSH)
      free_mem[fi_r] <= {1'b0, rel_r};
    if (cmd.op == OP_LATCH)
      rd_head_r <= free_mem[fi_get];
  end

  // Slot record memory.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CARVE || cmd.op == OP_NEWBUF) begin
      slot_len_mem[s_idx]  <= size_r;
      slot_off_mem[s_idx]  <= (cmd.op == OP_CARVE) ? buf_fill_r[walk_idx] : '0;
      slot_own_mem[s_idx]  <= (cmd.op == OP_CARVE) ? walk_idx
                              : bufs_used_r[BUF_W-1:0];
      slot_link_mem[s_idx] <= (SLOT_W+1)'(SLOTS);
    end else if (cmd.op == OP_PUSH) begin
      slot_link_mem[rel_r] <= head_r;
    end
    if (cmd.op == OP_RD_HEAD || cmd.op == OP_RD_SLOT) begin
      rd_len_r  <= slot_len_mem[rd_addr];
      rd_off_r  <= slot_off_mem[rd_addr];
      rd_own_r  <= slot_own_mem[rd_addr];
      rd_link_r <= slot_link_mem[rd_addr];
    end
  end

  // Buffer tables and chain heads.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CARVE)
      buf_fill_r[walk_idx] <= buf_fill_r[walk_idx] + ELEM_W'(size_r);
    if (cmd.op == OP_NEWBUF) begin
      buf_fmt_r[bufs_used_r[BUF_W-1:0]]  <= fmt_r;
      buf_cap_r[bufs_used_r[BUF_W-1:0]]  <= new_cap;
      buf_fill_r[bufs_used_r[BUF_W-1:0]] <= ELEM_W'(size_r);
      buf_link_r[bufs_used_r[BUF_W-1:0]] <= chain_head_now;
      chain_r[fmt_r] <= bufs_used_r;
    end
  end

  // Beat capture, walker and result register.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        cmd_r  <= in_cmd;
        fmt_r  <= in_fmt;
        size_r <= size_rnd;
        rel_r  <= in_rel;
        bad_r  <= bad_now;
        fi_r   <= fi_get;
      end
      OP_RD_HEAD: ;
      OP_RD_SLOT: begin
        if (cmd_r == CMD_RELEASE) begin
          fi_r <= fi_rel;
        end
      end
      OP_WALK: walk_r <= chain_head_now;
      OP_STEP: walk_r <= buf_link_r[walk_idx];
      OP_POP: begin
        res_status <= ST_REUSED;
        res_slot   <= rd_head_r[SLOT_W-1:0];
        res_buf    <= rd_own_r;
        res_off    <= rd_off_r;
        res_len    <= rd_len_r;
      end
      OP_CARVE: begin
        res_status <= ST_CARVED;
        res_slot   <= s_idx;
        res_buf    <= walk_idx;
        res_off    <= buf_fill_r[walk_idx];
        res_len    <= size_r;
      end
      OP_NEWBUF: begin
        res_status <= ST_NEWBUF;
        res_slot   <= s_idx;
        res_buf    <= bufs_used_r[BUF_W-1:0];
        res_off    <= '0;
        res_len    <= size_r;
      end
      OP_PUSH: begin
        res_status <= ST_RELEASED;
        res_slot   <= rel_r;
        res_buf    <= rd_own_r;
        res_off    <= rd_off_r;
        res_len    <= rd_len_r;
      end
      OP_EMIT_BAD: begin
        res_status <= ST_BADSIZE;
        res_slot   <= '0;
        res_buf    <= '0;
        res_off    <= '0;
        res_len    <= '0;
      end
      OP_EMIT_NOS: begin
        res_status <= ST_NOSTORE;
        res_slot   <= '0;
        res_buf    <= '0;
        res_off    <= '0;
        res_len    <= size_r;
      end
      OP_EMIT_IGN: begin
        res_status <= ST_RELEASED;
        res_slot   <= rel_r;
        res_buf    <= '0;
        res_off    <= '0;
        res_len    <= '0;
      end
      default: ;
    endcase
  end

  // Free head for a push is read in the cycle after its class is registered in fi_r.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD_HEAD && cmd_r == CMD_RELEASE) head_r <= '0;
    else if (cmd.op == OP_WALK) head_r <= free_mem[fi_r];
  end

endmodule

>>> sv/fssa_ctrl.sv
// Controller of the slot allocator: sequences memory reads, the chain walk
// and the result hand-off. Depends on fssa_pkg.
module fssa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  output logic                 in_rdy,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output logic                 res_load,
  output fssa_pkg::fssa_cmd_t  cmd,
  input  fssa_pkg::fssa_stat_t stat
);
  import fssa_pkg::*;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_RSLOT = 4'd3;
  localparam logic [3:0] S_GETCK = 4'd4;
  localparam logic [3:0] S_WALK  = 4'd5;
  localparam logic [3:0] S_TEST  = 4'd6;
  localparam logic [3:0] S_RHEAD = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;

  assign in_rdy  = (state_r == S_IDLE);
  assign out_vld = out_vld_r;

  always_comb begin
    state_nxt   = state_r;
    out_vld_nxt = out_vld_r && !out_rdy;
    res_load    = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_INIT: if (stat.init_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_release) begin
          if (stat.rel_ignored) begin
            cmd.op = OP_EMIT_IGN; state_nxt = S_OUT;
          end else begin
            cmd.op = OP_RD_HEAD; state_nxt = S_RSLOT;
          end
        end else if (stat.bad_req) begin
          cmd.op = OP_EMIT_BAD; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_RD_SLOT; state_nxt = S_GETCK;
        end
      end
      S_RSLOT: begin
        cmd.op = OP_RD_SLOT; state_nxt = S_RHEAD;
      end
      S_RHEAD: begin
        cmd.op = OP_WALK; state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.op = OP_PUSH; state_nxt = S_OUT;
      end
      S_GETCK: begin
        if (stat.free_hit) begin
          cmd.op = OP_POP; state_nxt = S_OUT;
        end else if (stat.slots_full) begin
          cmd.op = OP_EMIT_NOS; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_WALK; state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (stat.walk_end) begin
          if (stat.buffers_full) cmd.op = OP_EMIT_NOS;
          else cmd.op = OP_NEWBUF;
          state_nxt = S_OUT;
        end else if (stat.walk_fits) begin
          cmd.op = OP_CARVE; state_nxt = S_OUT;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_vld_r || out_rdy) begin
          res_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

>>> sv/format_sized_slot_allocator_core.sv
// Top level of the format-sized slot allocator: stream ports, config
// register, controller and datapath. Depends on fssa_pkg, fssa_ctrl,
// fssa_datapath.
//
//   Channel | Direction | Contents
//   in_     | input     | tdata: request_size, freed_slot; tuser: command, format
//   out_    | output    | tdata: status, slot_id, buffer_id, start_offset, rounded_size
//   cfg_    | input     | min_buffer_elements write
//
// Each beat is decoded; a bad size or an ignored release then goes to output,
// a reuse or a full slot pool after the slot record at the free head is read,
// a release after its slot record and free head are read and it is pushed, and
// a get that walks the chain after testing its buffers in turn, opening a new
// one if none fits. After reset a sweep clears the free-list heads; no beat is
// taken then. A result waits in the output register until taken; a new beat may
// be accepted meanwhile; the datapath holds its result until the register frees.
module format_sized_slot_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_size[15:0], freed_slot[27:16], zero
  input  logic [5:0]  in_tuser,   // command[0], format[5:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], slot_id[14:3], buffer_id[19:15], start_offset[35:20],
  // rounded_size[47:36]
  output logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import fssa_pkg::*;

  fssa_cmd_t   cmd;
  fssa_stat_t  stat;
  logic [15:0] min_buf_r;
  logic        res_load;
  logic [47:0] out_data_r;
  logic [2:0]  res_status;
  logic [11:0] res_slot;
  logic [4:0]  res_buf;
  logic [15:0] res_off;
  logic [11:0] res_len;

  // Minimum buffer size register.
  always_ff @(posedge clk) begin
    if (!rst_n) min_buf_r <= MIN_BUF_RESET;
    else if (cfg_wr_en) min_buf_r <= cfg_wr_data;
  end

  fssa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && in_tready),
    .in_rdy   (in_tready),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .res_load (res_load),
    .cmd      (cmd),
    .stat     (stat)
  );

  fssa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .min_buf    (min_buf_r),
    .in_cmd     (in_tuser[0]),
    .in_fmt     (in_tuser[5:1]),
    .in_size    (in_tdata[15:0]),
    .in_rel     (in_tdata[27:16]),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_buf    (res_buf),
    .res_off    (res_off),
    .res_len    (res_len)
  );

  // Output register: holds the beat on offer while the next item runs.
  always_ff @(posedge clk) begin
    if (res_load) out_data_r <= {res_len, res_off, res_buf, res_slot, res_status};
  end

  assign out_tdata = out_data_r;

endmodule

>>> dv/format_sized_slot_allocator_checker.sv
// Checker for the format-sized slot allocator: watches the input, config and
// result channels, predicts every result and compares field by field.
// Depends on fssa_pkg.
module format_sized_slot_allocator_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [5:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          results_pending,
  output int          slots_granted
);
  timeunit 1ns;
  timeprecision 1ps;
  import fssa_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot_id;
    logic [BUF_W-1:0]  buffer_id;
    logic [ELEM_W-1:0] start_offset;
    logic [LEN_W-1:0]  rounded_size;
  } alloc_result_t;

  // Shadow allocator state.
  int unsigned min_elems;
  int unsigned len_of_slot  [SLOTS];
  int unsigned off_of_slot  [SLOTS];
  int unsigned buf_of_slot  [SLOTS];
  int unsigned next_free    [SLOTS];
  int unsigned free_list_top[FORMATS*SIZE_CLASSES];
  int unsigned chain_top    [FORMATS];
  int unsigned fmt_of_buf   [BUFFERS];
  int unsigned fill_of_buf  [BUFFERS];
  int unsigned cap_of_buf   [BUFFERS];
  int unsigned next_buf     [BUFFERS];
  int unsigned slot_count;
  int unsigned buf_count;

  alloc_result_t expected_results[$];

  function automatic alloc_result_t mk(int unsigned st, int unsigned s, int unsigned b,
                                       int unsigned o, int unsigned l);
    alloc_result_t r;
    r.status = st[ST_W-1:0];
    r.slot_id = s[SLOT_W-1:0];
    r.buffer_id = b[BUF_W-1:0];
    r.start_offset = o[ELEM_W-1:0];
    r.rounded_size = l[LEN_W-1:0];
    return r;
  endfunction

  // Next-state and result for one request beat.
  function automatic alloc_result_t allocate(logic cmd, int unsigned fmt, int unsigned req,
                                             int unsigned rel);
    int unsigned size, cls, fi, s, b, cap;
    if (cmd == CMD_RELEASE) begin
      if (rel >= slot_count) return mk(ST_RELEASED, rel, 0, 0, 0);
      b = buf_of_slot[rel];
      cls = len_of_slot[rel] / 32 - 1;
      fi = fmt_of_buf[b] * SIZE_CLASSES + cls;
      next_free[rel] = free_list_top[fi];
      free_list_top[fi] = rel;
      return mk(ST_RELEASED, rel, b, off_of_slot[rel], len_of_slot[rel]);
    end
    size = (req + 31) & ~32'd31;
    if (req == 0 || size > SIZE_CLASSES * 32 || fmt >= FORMATS)
      return mk(ST_BADSIZE, 0, 0, 0, 0);
    cls = size / 32 - 1;
    fi = fmt * SIZE_CLASSES + cls;
    s = free_list_top[fi];
    if (s < SLOTS) begin
      free_list_top[fi] = next_free[s];
      return mk(ST_REUSED, s, buf_of_slot[s], off_of_slot[s], len_of_slot[s]);
    end
    if (slot_count >= SLOTS) return mk(ST_NOSTORE, 0, 0, 0, size);
    s = slot_count;
    b = chain_top[fmt];
    while (b < BUFFERS) begin
      if (cap_of_buf[b] - fill_of_buf[b] >= size) begin
        len_of_slot[s] = size;
        off_of_slot[s] = fill_of_buf[b];
        buf_of_slot[s] = b;
        next_free[s] = SLOTS;
        fill_of_buf[b] += size;
        slot_count++;
        return mk(ST_CARVED, s, b, off_of_slot[s], size);
      end
      b = next_buf[b];
    end
    if (buf_count >= BUFFERS) return mk(ST_NOSTORE, 0, 0, 0, size);
    b = buf_count++;
    cap = (min_elems > size) ? min_elems : size;
    next_buf[b] = chain_top[fmt];
    chain_top[fmt] = b;
    fmt_of_buf[b] = fmt;
    cap_of_buf[b] = cap;
    fill_of_buf[b] = size;
    len_of_slot[s] = size;
    off_of_slot[s] = 0;
    buf_of_slot[s] = b;
    next_free[s] = SLOTS;
    slot_count++;
    return mk(ST_NEWBUF, s, b, 0, size);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign slots_granted = slot_count;

  // Compare result beats first, then predict for the request beat at this edge.
  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst_n) begin
      min_elems = MIN_BUF_RESET;
      slot_count = 0;
      buf_count = 0;
      foreach (free_list_top[i]) free_list_top[i] = SLOTS;
      foreach (chain_top[i]) chain_top[i] = BUFFERS;
      expected_results.delete();
      results_pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.slot_id = out_tdata[14:3];
        got.buffer_id = out_tdata[19:15];
        got.start_offset = out_tdata[35:20];
        got.rounded_size = out_tdata[47:36];
        if (expected_results.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.slot_id != want.slot_id) report_mismatch("slot_id", got.slot_id, want.slot_id);
          if (got.buffer_id != want.buffer_id)
            report_mismatch("buffer_id", got.buffer_id, want.buffer_id);
          if (got.start_offset != want.start_offset)
            report_mismatch("start_offset", got.start_offset, want.start_offset);
          if (got.rounded_size != want.rounded_size)
            report_mismatch("rounded_size", got.rounded_size, want.rounded_size);
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(allocate(in_tuser[0], in_tuser[5:1], in_tdata[15:0],
                                            in_tdata[27:16]));
      if (cfg_wr_en) min_elems = cfg_wr_data;
      results_pending = expected_results.size();
    end
  end
endmodule

>>> dv/format_sized_slot_allocator_core_tb.sv
// Testbench top for the format-sized slot allocator: clock, reset, request
// stimulus, result back-pressure and the verdict.
// Depends on fssa_pkg, format_sized_slot_allocator_core and its checker.
module format_sized_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fssa_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [5:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  int          fail_count, results_pending, slots_granted;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          results_taken = 0;

  always #5 clk = ~clk;

  format_sized_slot_allocator_core u_top (.*);
  format_sized_slot_allocator_checker u_chk (.*);

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold-off so the
  // block backs up into its input.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) results_taken++;
    if (results_taken == 300) begin
      results_taken++;
      out_tready <= 1'b0;
      repeat (400) @(posedge clk);
    end
    if ((results_taken / 150) % 3 == 1) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // One request beat, in bursts with random gaps between them.
  task automatic send_request(logic cmd, int unsigned fmt, int unsigned req,
                              int unsigned rel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= {fmt[4:0], cmd};
    in_tdata <= {4'b0, rel[11:0], req[15:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  // Let the last accepted beat be counted first, then wait until all are back.
  task automatic wait_drained();
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Drain all results, let the block settle, then write the minimum size.
  task automatic set_min_size(int unsigned value);
    in_tvalid <= 1'b0;
    burst_left = 0;
    wait_drained();
    repeat (50) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[15:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random mix weighted toward small sizes and live slots.
  task automatic random_request();
    int unsigned pick, fmt, req;
    pick = $urandom_range(0, 99);
    fmt = ($urandom_range(0, 19) == 0) ? $urandom_range(18, 31) : $urandom_range(0, 17);
    case ($urandom_range(0, 9))
      0: req = $urandom_range(0, 65535);
      1: req = $urandom_range(1025, 2048);
      2: req = 0;
      default: req = $urandom_range(1, 256);
    endcase
    if (pick < 55)
      send_request(CMD_GET, fmt, req, $urandom_range(0, 4095));
    else if (pick < 95)
      send_request(CMD_RELEASE, $urandom_range(0, 31), $urandom_range(0, 65535),
                   $urandom_range(0, slots_granted + 4));
    else
      send_request(CMD_RELEASE, fmt, req, $urandom_range(0, 4095));
  endtask

  initial begin
    int unsigned min_sizes[4] = '{65535, 1, 0, 2048};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, reuse, carve, new buffer, releases and ignored releases, bad sizes and formats.
    send_request(CMD_GET, 0, 1, 0);
    send_request(CMD_GET, 0, 32, 0);
    send_request(CMD_GET, 0, 33, 0);
    send_request(CMD_GET, 0, 2048, 0);
    send_request(CMD_GET, 0, 2049, 0);
    send_request(CMD_GET, 0, 0, 0);
    send_request(CMD_GET, 0, 65535, 0);
    send_request(CMD_GET, 17, 100, 0);
    send_request(CMD_GET, 18, 100, 0);
    send_request(CMD_GET, 31, 100, 4095);
    send_request(CMD_RELEASE, 0, 0, 0);
    send_request(CMD_RELEASE, 0, 0, 0);
    send_request(CMD_GET, 0, 20, 0);
    send_request(CMD_GET, 0, 32, 0);
    send_request(CMD_GET, 0, 1, 0);
    send_request(CMD_RELEASE, 31, 65535, 4095);
    send_request(CMD_RELEASE, 0, 0, 3);
    set_min_size(0);
    send_request(CMD_GET, 5, 64, 0);
    send_request(CMD_GET, 5, 32, 0);

    // Random phases over several minimum buffer sizes.
    foreach (min_sizes[p]) begin
      set_min_size(min_sizes[p]);
      repeat (240) random_request();
      // Sender pause until every result is back.
      in_tvalid <= 1'b0;
      burst_left = 0;
      wait_drained();
    end

    // Small gets into the open buffers, then releases of live slots and reuse.
    set_min_size(65535);
    for (int i = 0; i < 60; i++) send_request(CMD_GET, i % 18, 32, 0);
    for (int i = 0; i < 40; i++) begin
      send_request(CMD_RELEASE, 0, 0, $urandom_range(0, slots_granted));
      send_request(CMD_GET, $urandom_range(0, 17), $urandom_range(1, 2048), 0);
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
